// ===== hdl/assert_macros.svh =====
// Assertion macros for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_HOLDS(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (prop)) else $error(msg);

// Condition must never be seen outside reset.
`define ASSERT_NEVER(lbl, ck, rs, cond, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) !(cond)) else $error(msg);

`endif

// ===== hdl/rgbcc_pkg.sv =====
`timescale 1ns / 1ps

package rgbcc_pkg;

  // Target colour codes
  typedef enum logic [2:0] {
    TGT_BLUE   = 3'd0,
    TGT_YELLOW = 3'd1,
    TGT_GREEN  = 3'd2,
    TGT_RED    = 3'd3,
    TGT_PURPLE = 3'd4
  } target_t;

  // Luminance L = 2126r + 7152g + 722b, intensity times 10^4
  localparam int LumW    = 22;
  localparam int LumR    = 2126;
  localparam int LumG    = 7152;
  localparam int LumB    = 722;

  // Thresholds, all at the luminance scale or a fixed multiple of it
  localparam int PurpleOffset = 100000;
  localparam int PurpleBand   = 300000;
  localparam int BlueBand     = 30000000;
  localparam int RedOffset    = 1500000;
  localparam int RedBrightL   = 2300000;
  localparam int RedCap       = 1000000;
  localparam int GreenOffset  = 1570000;
  localparam int GreenBand    = 30000000;
  localparam int GreenBrightL = 2000000;
  localparam int GreenCap     = 30000000;

  typedef struct packed {
    logic floor_hit;
    logic purple_pre;
    logic blue_pre;
    logic red_hit;
    logic green_pre;
  } class_flags_t;

endpackage

// ===== hdl/rgbcc_ratio_tests.sv =====
`timescale 1ns / 1ps

module rgbcc_ratio_tests
  import rgbcc_pkg::*;
(
  input  logic [LumW-1:0] lum,
  input  logic [7:0]      r,
  input  logic [7:0]      g,
  input  logic [7:0]      b,
  output class_flags_t    flags
);

  logic signed [31:0] ls, rs, gs, bs;
  logic signed [31:0] purple_d, blue_d, green_d;
  logic               floor_r, floor_g, floor_b;
  logic               red_strong, red_bright, green_near, green_bright;

  assign ls = $signed({10'd0, lum});
  assign rs = $signed({24'd0, r});
  assign gs = $signed({24'd0, g});
  assign bs = $signed({24'd0, b});

  // Floor band: 0.75*I < c < 1.25*I, cross-multiplied
  assign floor_r = (rs * 8000 < ls) && (rs * 40000 > ls * 3);
  assign floor_g = (gs * 8000 < ls) && (gs * 40000 > ls * 3);
  assign floor_b = (bs * 8000 < ls) && (bs * 40000 > ls * 3);

  assign purple_d = gs * 10000 - ls + PurpleOffset;
  assign blue_d   = gs * 1000000 - ls * 107;
  assign green_d  = gs * 1000000 - ls * 108 - GreenOffset;

  assign red_strong   = rs * 100000 > ls * 14 - RedOffset;
  assign red_bright   = (ls > RedBrightL) && (r > 8'd250);
  assign green_near   = (green_d < GreenBand) && (green_d > -GreenBand);
  assign green_bright = (ls > GreenBrightL) && (g > 8'd225);

  always_comb begin
    flags.floor_hit  = floor_r && floor_g && floor_b;
    flags.purple_pre = (r > g) && (b > g) &&
                       (purple_d < PurpleBand) && (purple_d > -PurpleBand);
    flags.blue_pre   = (bs * 20 > gs * 21) && (bs * 20 > rs * 21) &&
                       (blue_d < BlueBand) && (blue_d > -BlueBand);
    flags.red_hit    = (rs * 10 > gs * 13) && (rs * 10 > bs * 13) &&
                       (red_strong || red_bright) &&
                       (gs * 100000 < ls * 9 + RedCap) &&
                       (bs * 100000 < ls * 9 + RedCap);
    flags.green_pre  = (gs * 10 > rs * 9) && (gs * 10 > bs * 9) &&
                       (green_near || green_bright) &&
                       (rs * 1000000 < ls * 95 + GreenCap) &&
                       (bs * 1000000 < ls * 95 + GreenCap);
  end

endmodule

// ===== hdl/rgb_ratio_color_classifier.sv =====
`timescale 1ns / 1ps
// Pixel colour classifier, one RGB pixel in, one mask byte out.
//
// Input channel: in_valid/in_ready with red_level, green_level, blue_level.
// Output channel: out_valid/out_ready with mask_value, 255 when the pixel
// belongs to the class chosen by target_color, otherwise 0. A yellow target
// or an unused code always gives 0.
// Configuration: cfg_write_en writes cfg_write_data into target_color at the
// clock edge; write it only while no pixel is in flight.
//
// Three register stages: luminance, ratio tests, class select into the output
// register. out_valid rises once an accepted pixel has passed all three, and
// throughput is one pixel per clock while out_ready is high.
// Each stage holds when the stage after it is full and stalled, so an empty
// stage still takes a beat while out_ready is low; nothing is lost or
// repeated under backpressure.
// Reset (rst, synchronous) empties the pipeline and sets the target to blue.
`include "assert_macros.svh"

module rgb_ratio_color_classifier
  import rgbcc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] red_level,
  input  logic [7:0] green_level,
  input  logic [7:0] blue_level,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] mask_value,
  input  logic       cfg_write_en,
  input  logic [2:0] cfg_write_data
);

  logic [2:0]      target_color;
  logic            v1, v2, v3;
  logic            en1, en2, en3;
  logic [LumW-1:0] lum1;
  logic [7:0]      r1, g1, b1;
  class_flags_t    flags_next, flags2;
  logic            purple_c, blue_c, green_c, hit;
  logic [7:0]      mask;

  // Advance a stage when it is empty or the next one moves
  assign en3      = !v3 || out_ready;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_color <= TGT_BLUE;
    end else if (cfg_write_en) begin
      target_color <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  // Stage 1: luminance
  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      lum1 <= LumW'(red_level) * LumW'(LumR) + LumW'(green_level) * LumW'(LumG) +
              LumW'(blue_level) * LumW'(LumB);
      r1   <= red_level;
      g1   <= green_level;
      b1   <= blue_level;
    end
  end

  rgbcc_ratio_tests u_tests (
    .lum   (lum1),
    .r     (r1),
    .g     (g1),
    .b     (b1),
    .flags (flags_next)
  );

  // Stage 2: ratio test flags
  always_ff @(posedge clk) begin
    if (en2 && v1) begin
      flags2 <= flags_next;
    end
  end

  assign purple_c = flags2.purple_pre && !flags2.floor_hit;
  assign blue_c   = flags2.blue_pre && !purple_c;
  assign green_c  = flags2.green_pre && !blue_c && !purple_c && !flags2.red_hit;

  always_comb begin
    case (target_color)
      TGT_BLUE:   hit = blue_c;
      TGT_GREEN:  hit = green_c;
      TGT_RED:    hit = flags2.red_hit;
      TGT_PURPLE: hit = purple_c;
      default:    hit = 1'b0;
    endcase
  end

  // Stage 3: output register
  always_ff @(posedge clk) begin
    if (en3 && v2) begin
      mask <= hit ? 8'hFF : 8'h00;
    end
  end

  assign out_valid  = v3;
  assign mask_value = mask;

  `ASSERT_HOLDS(a_stage1_hold, clk, rst, (v1 && !en2) |=> v1, "stage 1 beat dropped")
  `ASSERT_HOLDS(a_ready_when_empty, clk, rst, !v3 |-> in_ready, "stalled with empty output")
  `ASSERT_NEVER(a_yellow_silent, clk, rst, (target_color == TGT_YELLOW) && hit, "yellow hit")

endmodule

// ===== bench/rgb_ratio_color_classifier_tb.sv =====
`timescale 1ns / 1ps

module rgb_ratio_color_classifier_tb;
  import rgbcc_pkg::*;

  localparam longint UNIT = 1000000;
  localparam int DRAIN_PAD = 4;
  localparam int MAX_REPORTS = 10;
  // Selector codes with no colour class behind them
  localparam logic [2:0] TGT_SPARE_LO  = 3'd5;
  localparam logic [2:0] TGT_SPARE_MID = 3'd6;
  localparam logic [2:0] TGT_SPARE_TOP = 3'd7;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] red_level = 8'd0;
  logic [7:0] green_level = 8'd0;
  logic [7:0] blue_level = 8'd0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] mask_value;
  logic       cfg_write_en = 1'b0;
  logic [2:0] cfg_write_data = 3'd0;

  logic [2:0] cur_target = TGT_BLUE;
  logic [7:0] expected_masks [$];
  logic [7:0] wanted_mask;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  int         rx_hold = 0;
  int         fail_count = 0;

  rgb_ratio_color_classifier DUT (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .red_level      (red_level),
    .green_level    (green_level),
    .blue_level     (blue_level),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .mask_value     (mask_value),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic longint magnitude(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic logic in_floor_band(longint c, longint q);
    return (100 * c * UNIT < 125 * q) && (100 * c * UNIT > 75 * q);
  endfunction

  function automatic logic [7:0] clamp_level(int v);
    return (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : v[7:0];
  endfunction

  // q is the intensity scaled by 10^6, so every ratio test stays exact
  function automatic logic [7:0] predict_mask(logic [2:0] sel, logic [7:0] rl,
                                              logic [7:0] gl, logic [7:0] bl);
    longint r, g, b, q;
    logic floor_px, purple_px, blue_px, red_px, green_px;
    logic red_strong, red_bright, green_near, green_bright, hit;
    r = rl;
    g = gl;
    b = bl;
    q = (2126 * r + 7152 * g + 722 * b) * 100;
    floor_px = in_floor_band(r, q) && in_floor_band(g, q) && in_floor_band(b, q);
    purple_px = (r > g) && (b > g) &&
                (magnitude(g * UNIT - (q - 10 * UNIT)) < 30 * UNIT) && !floor_px;
    blue_px = (100 * b > 105 * g) && (100 * b > 105 * r) &&
              (magnitude(100 * g * UNIT - 107 * q) < 3000 * UNIT) && !purple_px;
    red_strong = 10 * r * UNIT > 14 * q - 150 * UNIT;
    red_bright = (q > 230 * UNIT) && (r > 250);
    red_px = (10 * r > 13 * g) && (10 * r > 13 * b) && (red_strong || red_bright) &&
             (10 * g * UNIT < 9 * q + 100 * UNIT) && (10 * b * UNIT < 9 * q + 100 * UNIT);
    green_near = magnitude(100 * g * UNIT - 108 * q - 157 * UNIT) < 3000 * UNIT;
    green_bright = (q > 200 * UNIT) && (g > 225);
    green_px = (10 * g > 9 * r) && (10 * g > 9 * b) && (green_near || green_bright) &&
               (100 * r * UNIT < 95 * q + 3000 * UNIT) &&
               (100 * b * UNIT < 95 * q + 3000 * UNIT) &&
               !blue_px && !purple_px && !red_px;
    case (sel)
      TGT_BLUE:   hit = blue_px;
      TGT_GREEN:  hit = green_px;
      TGT_RED:    hit = red_px;
      TGT_PURPLE: hit = purple_px;
      default:    hit = 1'b0;
    endcase
    return hit ? 8'd255 : 8'd0;
  endfunction

  // Enter and leave at a falling edge; hold the beat until it is taken
  task automatic send_pixel(logic [7:0] rv, logic [7:0] gv, logic [7:0] bv);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    red_level = rv;
    green_level = gv;
    blue_level = bv;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    expected_masks.push_back(predict_mask(cur_target, rv, gv, bv));
  endtask

  task automatic wait_for_results();
    in_valid = 1'b0;
    while (expected_masks.size() != 0) @(negedge clk);
    repeat (DRAIN_PAD) @(negedge clk);
  endtask

  task automatic write_target(logic [2:0] code);
    wait_for_results();
    cfg_write_en = 1'b1;
    cfg_write_data = code;
    @(negedge clk);
    cfg_write_en = 1'b0;
    cur_target = code;
  endtask

  always @(negedge clk) begin
    if (rx_hold > 0) begin
      out_ready = 1'b0;
      rx_hold = rx_hold - 1;
    end else begin
      out_ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_masks.size() == 0) begin
        fail_count = fail_count + 1;
        if (fail_count <= MAX_REPORTS)
          $display("unexpected mask beat %0d with nothing pending", mask_value);
      end else begin
        wanted_mask = expected_masks.pop_front();
        if (mask_value !== wanted_mask) begin
          fail_count = fail_count + 1;
          if (fail_count <= MAX_REPORTS)
            $display("mask_value mismatch: expected %0d, got %0d", wanted_mask, mask_value);
        end
      end
    end
  end

  // One pixel of each class, plus a purple-ish grey that the floor rule vetoes
  task automatic test_class_pixels();
    logic [2:0] targets [4] = '{TGT_BLUE, TGT_GREEN, TGT_RED, TGT_PURPLE};
    send_idle_pct = 0;
    recv_stall_pct = 0;
    foreach (targets[i]) begin
      write_target(targets[i]);
      send_pixel(8'd0, 8'd50, 8'd200);
      send_pixel(8'd120, 8'd60, 8'd140);
      send_pixel(8'd110, 8'd100, 8'd110);
      send_pixel(8'd200, 8'd30, 8'd30);
      send_pixel(8'd30, 8'd150, 8'd30);
    end
  endtask

  // Yellow and the top spare code never match, even on a clear class pixel
  task automatic test_unused_targets();
    write_target(TGT_YELLOW);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd0);
    write_target(TGT_SPARE_TOP);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd0, 8'd50, 8'd200);
  endtask

  // Hold the output off long enough for the pipeline to fill and stall the input
  task automatic test_backpressure();
    write_target(TGT_RED);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    @(posedge clk);
    rx_hold = 200;
    @(negedge clk);
    repeat (40)
      send_pixel(8'($urandom_range(140, 255)), 8'($urandom_range(0, 100)),
                 8'($urandom_range(0, 100)));
    wait_for_results();
  endtask

  task automatic test_random_pixels();
    logic [2:0] phase_targets [12] = '{TGT_BLUE, TGT_GREEN, TGT_RED, TGT_PURPLE,
                                       TGT_YELLOW, TGT_SPARE_LO, TGT_SPARE_MID,
                                       TGT_SPARE_TOP, TGT_GREEN, TGT_PURPLE,
                                       TGT_RED, TGT_BLUE};
    int style, lead, peak, base;
    int lvl [3];
    foreach (phase_targets[p]) begin
      write_target(phase_targets[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
        default: begin send_idle_pct = 36; recv_stall_pct = 36; end
      endcase
      repeat (100) begin
        style = $urandom_range(9);
        if (style <= 3) begin
          foreach (lvl[c]) lvl[c] = $urandom_range(255);
        end else if (style == 4) begin
          foreach (lvl[c]) lvl[c] = $urandom_range(1) ? 255 : 0;
        end else if (style <= 6) begin
          // one channel leads, the others trail it
          lead = $urandom_range(2);
          peak = $urandom_range(100, 255);
          foreach (lvl[c]) lvl[c] = (c == lead) ? peak : $urandom_range(peak);
        end else if (style <= 8) begin
          // purple-like: red and blue above a moderate green
          lvl[1] = $urandom_range(150);
          lvl[0] = lvl[1] + $urandom_range(1, 120);
          lvl[2] = lvl[1] + $urandom_range(1, 120);
        end else begin
          base = $urandom_range(255);
          foreach (lvl[c]) lvl[c] = base + $urandom_range(40) - 20;
        end
        send_pixel(clamp_level(lvl[0]), clamp_level(lvl[1]), clamp_level(lvl[2]));
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_class_pixels();
    test_unused_targets();
    test_backpressure();
    test_random_pixels();
    wait_for_results();
    repeat (DRAIN_PAD) @(negedge clk);
    if (fail_count == 0) begin
      $display("rgb_ratio_color_classifier_tb: done, clean");
    end else begin
      $display("rgb_ratio_color_classifier_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("rgb_ratio_color_classifier_tb: done, errors");
    $finish;
  end

endmodule
